// ===== hdl/clwr_pkg.sv =====
// shared types, widths and codes for the code line window refine block
`default_nettype none
package clwr_pkg;

  localparam int VALUE_W    = 16;
  localparam int RADIUS_W   = 4;
  localparam int GRAD_W     = 16;
  localparam int MAX_RADIUS = 15;
  localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;
  localparam int ADDR_W     = 5;
  localparam int MEM_DEPTH  = 32;
  localparam int MAX_LINE   = 4096;
  localparam int POS_W      = 12;
  localparam int ONE_Q6     = 64;
  localparam int OFS_W      = 6;
  localparam int TOL_W      = 20;
  localparam int WGT_W      = 5;
  localparam int SUM_W      = 26;
  localparam int SUMW_W     = 9;
  localparam int CNT_W      = 5;
  localparam int MAG_W      = 24;
  localparam int NUM_W      = 25;
  localparam int DEN_W      = 10;
  localparam int QUO_W      = 16;
  localparam int REM_W      = 9;
  localparam int STEP_W     = 4;
  localparam int RES_W      = 18;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GRADIENT = 1'b1;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET   = 4'd7;
  localparam logic [GRAD_W-1:0]   GRADIENT_RESET = 16'd64;

  typedef struct packed {
    logic               known;
    logic [VALUE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/clwr_in_if.sv =====
// input sample channel: valid/ready handshake with code payload
`default_nettype none
interface clwr_in_if import clwr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] code_value;
  logic               code_known;
  logic               line_end;

  modport source (output valid, output code_value, output code_known, output line_end,
                  input ready);
  modport sink (input valid, input code_value, input code_known, input line_end,
                output ready);
endinterface
`default_nettype wire

// ===== hdl/clwr_out_if.sv =====
// result channel: valid/ready handshake with refined code payload
`default_nettype none
interface clwr_out_if import clwr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] refined_value;
  logic               refined_known;
  logic               line_last;

  modport source (output valid, output refined_value, output refined_known,
                  output line_last, input ready);
  modport sink (input valid, input refined_value, input refined_known,
                input line_last, output ready);
endinterface
`default_nettype wire

// ===== hdl/clwr_div.sv =====
// serial restoring divider, one quotient bit per cycle
`default_nettype none
module clwr_div import clwr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [REM_W-1:0]  rem;
  logic [QUO_W-1:0]  qn;
  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  trial;
  logic              ge;

  // quotient is known to fit in QUO_W bits, so the top bits start as remainder
  assign trial = {rem, qn[QUO_W-1]};
  assign ge    = trial >= den;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num[NUM_W-1:QUO_W];
      qn  <= req.num[QUO_W-1:0];
      den <= req.den;
    end else if (busy) begin
      rem <= ge ? REM_W'(trial - den) : trial[REM_W-1:0];
      qn  <= {qn[QUO_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = qn;

endmodule
`default_nettype wire

// ===== hdl/code_line_window_refine.sv =====
// code line window refine: top level with window memory and tap sequencer
// Usage:
//   samples carries one pixel per item (code_value Q10.6, code_known, line_end);
//   results carries refined items in pixel order, lagging the input by radius.
//   cfg_we/cfg_index/cfg_data write radius (index 0) or max_gradient (index 1);
//   a radius write drops the partial line held in the window.
// Flow:
//   samples.ready is high only while the sequencer is idle. Each result goes
//   through the center fetch (S_CENTER, S_LOAD), the 2*radius+1 taps of the
//   shared compare/accumulate unit, a check step, the serial divider when the
//   weighted mean is applied, and an output step; an unknown center skips
//   straight from the fetch to the output step. An item that ends a line
//   produces up to radius+1 results back to back, one such run each. The
//   first radius items of a line produce nothing unless they end the line.
// Reset: radius 7, max_gradient 64, empty window, no result pending.
// Stall: one output register holds a finished result; the sequencer waits in
//   its output step while that register is full and not taken, and a new item
//   is accepted in idle after the last result of the previous one is loaded.
`default_nettype none
module code_line_window_refine import clwr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  clwr_in_if.sink               samples,
  clwr_out_if.source            results
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CENTER = 7'b0000010,
    S_LOAD   = 7'b0000100,
    S_TAP    = 7'b0001000,
    S_CHK    = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state;

  logic [RADIUS_W-1:0] radius;
  logic [GRAD_W-1:0]   max_gradient;
  logic [POS_W-1:0]    line_position;
  logic [ADDR_W-1:0]   fill;
  logic [ADDR_W-1:0]   head;

  entry_t            mem [MEM_DEPTH];
  entry_t            rd_a;
  entry_t            rd_b;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;

  logic [RADIUS_W-1:0] cur_c;
  logic                end_flag;
  logic signed [OFS_W-1:0] r_cnt;
  logic signed [OFS_W-1:0] rad_s;
  logic signed [OFS_W-1:0] c_s;
  logic signed [OFS_W-1:0] idx1;
  logic signed [OFS_W-1:0] idx2;
  logic signed [OFS_W-1:0] r_neg;
  logic [RADIUS_W-1:0]     abs_r;
  logic                    more_taps;

  logic [TOL_W-1:0] p_tol;
  logic [WGT_W-1:0] p_w;
  logic             p_in1;
  logic             p_in2;

  logic [VALUE_W-1:0]       center;
  logic signed [VALUE_W:0]  diff1;
  logic signed [VALUE_W:0]  diff2;
  logic signed [VALUE_W:0]  neg1;
  logic signed [VALUE_W:0]  neg2;
  logic                     ok1;
  logic                     ok2;
  logic signed [VALUE_W:0]  d_sel;
  logic signed [VALUE_W+WGT_W+1:0] prod;
  logic signed [SUM_W-1:0]  sum;
  logic [SUMW_W-1:0]        sumw;
  logic [CNT_W-1:0]         cnt;

  logic [SUM_W-1:0]  mag;
  logic              use_avg;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic signed [RES_W-1:0] q_s;
  logic signed [RES_W-1:0] res_s;
  logic [VALUE_W-1:0] res_sat;

  logic [VALUE_W-1:0] res_value;
  logic               res_known;
  logic               out_valid;
  logic               out_load;
  logic               accept;
  logic               has_first;

  assign accept        = samples.valid && samples.ready;
  assign samples.ready = (state == S_IDLE);
  assign has_first     = line_position >= POS_W'(radius);

  // tap offsets: r runs -radius..radius, window index c-r first, c+r as mirror
  assign rad_s     = $signed({2'b00, radius});
  assign c_s       = $signed({2'b00, cur_c});
  assign idx1      = c_s - r_cnt;
  assign idx2      = c_s + r_cnt;
  assign r_neg     = -r_cnt;
  assign abs_r     = r_cnt[OFS_W-1] ? r_neg[RADIUS_W-1:0] : r_cnt[RADIUS_W-1:0];
  assign more_taps = r_cnt <= rad_s;

  // age to address: newest entry sits at head
  assign addr_a = (state == S_CENTER) ? head - ADDR_W'(cur_c) : head - idx1[ADDR_W-1:0];
  assign addr_b = head - idx2[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[head + 1'b1] <= '{known: samples.code_known, value: samples.code_value};
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  // issue stage registers, evaluated in the next cycle together with the read data
  always_ff @(posedge clk) begin
    p_tol <= TOL_W'(abs_r) * TOL_W'(max_gradient) + TOL_W'(ONE_Q6);
    p_w   <= WGT_W'(radius) + WGT_W'(1) - WGT_W'(abs_r);
    p_in1 <= !idx1[OFS_W-1] && (idx1[ADDR_W-1:0] < fill);
    p_in2 <= !idx2[OFS_W-1] && (idx2[ADDR_W-1:0] < fill);
  end

  // shared compare and weighted accumulate unit
  assign diff1 = $signed({1'b0, rd_a.value}) - $signed({1'b0, center});
  assign diff2 = $signed({1'b0, rd_b.value}) - $signed({1'b0, center});
  assign neg1  = -diff1;
  assign neg2  = -diff2;
  assign ok1   = p_in1 && rd_a.known &&
                 (TOL_W'(diff1[VALUE_W] ? neg1[VALUE_W-1:0] : diff1[VALUE_W-1:0]) <= p_tol);
  assign ok2   = p_in2 && rd_b.known &&
                 (TOL_W'(diff2[VALUE_W] ? neg2[VALUE_W-1:0] : diff2[VALUE_W-1:0]) <= p_tol);
  assign d_sel = ok1 ? diff1 : neg2;
  assign prod  = $signed({{(VALUE_W+2){1'b0}}, p_w}) *
                 $signed({{(WGT_W+1){d_sel[VALUE_W]}}, d_sel});

  assign mag     = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign use_avg = (CNT_W'(radius) <= cnt) && (sumw != '0);

  assign div_req.start = (state == S_CHK) && use_avg;
  assign div_req.num   = {mag[MAG_W-1:0], 1'b0} + NUM_W'(sumw);
  assign div_req.den   = {sumw, 1'b0};

  clwr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign q_s   = sum[SUM_W-1] ? -$signed({2'b00, div_rsp.quo}) : $signed({2'b00, div_rsp.quo});
  assign res_s = $signed({2'b00, center}) + q_s;
  always_comb begin
    if (res_s[RES_W-1]) begin
      res_sat = '0;
    end else if (res_s[RES_W-2:VALUE_W] != '0) begin
      res_sat = '1;
    end else begin
      res_sat = res_s[VALUE_W-1:0];
    end
  end

  assign out_load = (state == S_OUT) && (!out_valid || results.ready);

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_LOAD: begin
        center    <= rd_a.value;
        sum       <= '0;
        sumw      <= '0;
        cnt       <= '0;
        res_value <= '0;
        res_known <= 1'b0;
      end
      S_TAP: begin
        if (ok1 || ok2) begin
          sum  <= sum + SUM_W'(prod);
          sumw <= sumw + SUMW_W'(p_w);
          cnt  <= cnt + 1'b1;
        end
      end
      S_CHK: begin
        res_value <= center;
        res_known <= 1'b1;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_value <= res_sat;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      results.refined_value <= res_value;
      results.refined_known <= res_known;
      results.line_last     <= end_flag && (cur_c == '0);
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      radius        <= RADIUS_RESET;
      max_gradient  <= GRADIENT_RESET;
      line_position <= '0;
      fill          <= '0;
      head          <= '0;
      cur_c         <= '0;
      end_flag      <= 1'b0;
      r_cnt         <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            head     <= head + 1'b1;
            end_flag <= samples.line_end;
            if (fill != ADDR_W'(WIN_DEPTH)) begin
              fill <= fill + 1'b1;
            end
            if (line_position != POS_W'(MAX_LINE - 1)) begin
              line_position <= line_position + 1'b1;
            end
            if (has_first) begin
              cur_c <= radius;
              state <= S_CENTER;
            end else if (samples.line_end) begin
              // short line: first pending center is the oldest sample
              cur_c <= line_position[RADIUS_W-1:0];
              state <= S_CENTER;
            end
          end
        end
        S_CENTER: begin
          r_cnt <= -rad_s;
          state <= S_LOAD;
        end
        S_LOAD: begin
          r_cnt <= r_cnt + 1'b1;
          state <= rd_a.known ? S_TAP : S_OUT;
        end
        S_TAP: begin
          if (more_taps) begin
            r_cnt <= r_cnt + 1'b1;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          state <= use_avg ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            if (end_flag && (cur_c != '0)) begin
              cur_c <= cur_c - 1'b1;
              state <= S_CENTER;
            end else begin
              state <= S_IDLE;
              if (end_flag) begin
                fill          <= '0;
                line_position <= '0;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RADIUS: begin
            radius        <= cfg_data[RADIUS_W-1:0];
            fill          <= '0;
            line_position <= '0;
          end
          CFG_MAX_GRADIENT: begin
            max_gradient <= cfg_data[GRAD_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign results.valid = out_valid;

`ifndef NO_ASSERTIONS
  // the center itself always supports the mean, so the weight total is never zero
  a_sumw_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_CHK |-> sumw != '0)
    else $error("weight total zero at check");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_CHK |-> cnt <= {radius, 1'b1})
    else $error("support count exceeds tap count");

  a_center_range: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> cur_c <= radius)
    else $error("center index beyond radius");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divider finished outside divide step");

  a_line_end_flush: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready && samples.line_end |=> state == S_CENTER)
    else $error("line end item did not start a flush");
`endif

endmodule
`default_nettype wire
